// ===== rtl/tcs_pkg.sv =====
package tcs_pkg;

  // texture geometry (powers of two)
  localparam int TEX_W_LG    = 6;
  localparam int TEX_H_LG    = 6;
  localparam int TEX_W       = 1 << TEX_W_LG;
  localparam int TEX_H       = 1 << TEX_H_LG;
  localparam int SCREEN_H    = 1024;
  localparam int STORE_AW    = 12;
  localparam int STORE_DEPTH = 1 << STORE_AW;

  // field widths
  localparam int COLOR_W  = 32;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 11;
  localparam int FRAC_W   = 16;
  localparam int HEIGHT_W = 16;
  localparam int END_W    = 12;
  localparam int DIST_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int VSHIFT_W = 11;
  localparam int SHADE_W  = 9;
  localparam int SHADE_FRAC = 8;

  // stream widths
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 56;
  localparam int KIND_W     = 2;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VSHIFT     = 1'b1;

  localparam logic [GAIN_W-1:0]   GAIN_RESET = 16'd256;
  localparam logic [COLOR_W-1:0]  KEY_COLOR  = 32'h0000_FF00;

  typedef enum logic [KIND_W-1:0] {
    KIND_TEXEL = 2'd0,
    KIND_SETUP = 2'd1,
    KIND_PIXEL = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [STORE_AW-1:0]   texel_index;
    logic [COLOR_W-1:0]    texel_color;
    logic [COL_W-1:0]      column;
    logic [FRAC_W-1:0]     wall_frac;
    logic                  hit_side;
    logic                  step_x_negative;
    logic                  step_y_positive;
    logic [HEIGHT_W-1:0]   wall_height;
    logic [END_W-1:0]      row_end;
    logic [DIST_W-1:0]     distance;
    logic [ROW_W-1:0]      row;
  } item_t;

  // handshake between front queue and back sequencer
  typedef struct packed {
    logic valid;
    item_t item;
  } front_t;

endpackage

// ===== rtl/tcs_ram.sv =====
module tcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tcs_front.sv =====
module tcs_front import tcs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [IN_DATA_W-1:0] s_axis_tdata_i,
  input  logic [KIND_W-1:0]    s_axis_tuser_i,
  output front_t               front_o,
  input  logic                 pop_i
);

  item_t       in_item;
  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  logic        pop;

  // unpack and classify the incoming transaction
  always_comb begin
    in_item.kind            = kind_e'(s_axis_tuser_i);
    in_item.texel_index     = s_axis_tdata_i[11:0];
    in_item.texel_color     = s_axis_tdata_i[43:12];
    in_item.column          = s_axis_tdata_i[53:44];
    in_item.wall_frac       = s_axis_tdata_i[69:54];
    in_item.hit_side        = s_axis_tdata_i[70];
    in_item.step_x_negative = s_axis_tdata_i[71];
    in_item.step_y_positive = s_axis_tdata_i[72];
    in_item.wall_height     = s_axis_tdata_i[88:73];
    in_item.row_end         = s_axis_tdata_i[100:89];
    in_item.distance        = s_axis_tdata_i[116:101];
    in_item.row             = s_axis_tdata_i[127:117];
  end

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item;
    end
  end

  assign front_o.valid = (cnt_q != 2'd0);
  assign front_o.item  = mem_q[rd_ptr_q];

endmodule

// ===== rtl/tcs_back.sv =====
module tcs_back import tcs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  front_t                front_i,
  output logic                  pop_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_SHADE, S_DIV_ROW, S_READ, S_SHADE
  } state_e;

  localparam int DIV_STEPS = (SHADE_FRAC > TEX_H_LG) ? SHADE_FRAC : TEX_H_LG;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int REM_W     = HEIGHT_W + 1;
  localparam int OFF_W     = HEIGHT_W + 2;
  localparam int NEG_W     = OFF_W + TEX_H_LG;

  state_e                 state_q;
  logic [GAIN_W-1:0]      gain_q;
  logic [VSHIFT_W-1:0]    vshift_q;
  logic [COL_W-1:0]       col_x_q;
  logic [TEX_W_LG-1:0]    tex_col_q;
  logic [HEIGHT_W-1:0]    height_q;
  logic [END_W-1:0]       end_q;
  logic [SHADE_W-1:0]     shade_q;
  logic [REM_W-1:0]       rem_q;
  logic [HEIGHT_W-1:0]    div_q;
  logic [DIV_STEPS-1:0]   quo_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [ROW_W-1:0]       row_q;
  logic                   out_valid_q;
  logic [COL_W-1:0]       out_x_q;
  logic [ROW_W-1:0]       out_y_q;
  logic [COLOR_W-1:0]     out_color_q;
  logic                   out_we_q;

  item_t                  it;
  logic                   start;
  logic [DIST_W-1:0]      d_eff;
  logic                   mirror;
  logic [TEX_W_LG-1:0]    tc;
  logic signed [OFF_W-1:0] offset;
  logic [OFF_W-1:0]       neg_mag;
  logic                   neg_zero_row;
  logic                   pos_in_range;
  logic [REM_W:0]         trial;
  logic                   ge;
  logic [REM_W-1:0]       rem_next;
  logic [DIV_STEPS-1:0]   quo_next;
  logic                   row_in;
  logic                   ram_we;
  logic [STORE_AW-1:0]    ram_raddr;
  logic [COLOR_W-1:0]     ram_rdata;
  logic [15:0]            prod_r, prod_g, prod_b;
  logic [COLOR_W-1:0]     shaded;
  logic                   is_key;
  logic [COLOR_W-1:0]     pix_color;

  assign it    = front_i.item;
  assign start = (state_q == S_IDLE) && front_i.valid && !out_valid_q;
  assign pop_o = start;

  // setup path
  assign d_eff  = (it.distance == '0) ? DIST_W'(1) : it.distance;
  assign mirror = (!it.hit_side && it.step_x_negative) || (it.hit_side && it.step_y_positive);
  assign tc     = mirror ? ~it.wall_frac[FRAC_W-1 -: TEX_W_LG]
                         : it.wall_frac[FRAC_W-1 -: TEX_W_LG];

  // row path: signed offset into the wall, then range checks before dividing
  assign offset = $signed(OFF_W'(it.row)) + $signed(OFF_W'(height_q >> 1))
                - $signed(OFF_W'(SCREEN_H / 2))
                - $signed({{(OFF_W-VSHIFT_W){vshift_q[VSHIFT_W-1]}}, vshift_q});
  assign neg_mag      = OFF_W'(-offset);
  assign neg_zero_row = ((NEG_W'(neg_mag) << TEX_H_LG) < NEG_W'(height_q));
  assign pos_in_range = (OFF_W'(offset) < OFF_W'(height_q));
  assign row_in       = ({1'b0, it.row} < end_q);

  // one restoring step of the shared divider
  assign trial    = {rem_q, 1'b0};
  assign ge       = (trial >= (REM_W+1)'(div_q));
  assign rem_next = ge ? REM_W'(trial - (REM_W+1)'(div_q)) : REM_W'(trial);
  assign quo_next = {quo_q[DIV_STEPS-2:0], ge};

  // shading; a shaded texel can itself land on the key value
  assign ram_we    = start && (it.kind == KIND_TEXEL);
  assign ram_raddr = {quo_q[TEX_H_LG-1:0], tex_col_q};
  assign prod_r    = 16'(ram_rdata[23:16] * shade_q);
  assign prod_g    = 16'(ram_rdata[15:8] * shade_q);
  assign prod_b    = 16'(ram_rdata[7:0] * shade_q);
  assign shaded    = {8'h00, prod_r[15:8], prod_g[15:8], prod_b[15:8]};
  assign is_key    = (ram_rdata == KEY_COLOR);
  assign pix_color = is_key ? ram_rdata : shaded;

  tcs_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (it.texel_index),
    .wdata_i (it.texel_color),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gain_q      <= GAIN_RESET;
      vshift_q    <= '0;
      col_x_q     <= '0;
      tex_col_q   <= '0;
      height_q    <= HEIGHT_W'(1);
      end_q       <= '0;
      shade_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LIGHT_GAIN: gain_q   <= cfg_data_i[GAIN_W-1:0];
          CFG_VSHIFT:     vshift_q <= cfg_data_i[VSHIFT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            out_x_q     <= '0;
            out_y_q     <= '0;
            out_color_q <= '0;
            out_we_q    <= 1'b0;
            row_q       <= it.row;
            unique case (it.kind)
              KIND_SETUP: begin
                col_x_q   <= it.column;
                tex_col_q <= tc;
                height_q  <= (it.wall_height == '0) ? HEIGHT_W'(1) : it.wall_height;
                end_q     <= it.row_end;
                if (gain_q >= d_eff) begin
                  shade_q     <= SHADE_W'(1 << SHADE_FRAC);
                  out_valid_q <= 1'b1;
                end else begin
                  rem_q   <= REM_W'(gain_q);
                  div_q   <= d_eff;
                  quo_q   <= '0;
                  cnt_q   <= CNT_W'(SHADE_FRAC);
                  state_q <= S_DIV_SHADE;
                end
              end
              KIND_PIXEL: begin
                out_x_q <= col_x_q;
                out_y_q <= it.row;
                if (offset < 0) begin
                  if (neg_zero_row) begin
                    quo_q   <= '0;
                    state_q <= S_READ;
                  end else begin
                    out_we_q    <= row_in;
                    out_valid_q <= 1'b1;
                  end
                end else if (pos_in_range) begin
                  rem_q   <= REM_W'(offset);
                  div_q   <= height_q;
                  quo_q   <= '0;
                  cnt_q   <= CNT_W'(TEX_H_LG);
                  state_q <= S_DIV_ROW;
                end else begin
                  out_we_q    <= row_in;
                  out_valid_q <= 1'b1;
                end
              end
              default: begin
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        S_DIV_SHADE: begin
          rem_q <= rem_next;
          quo_q <= quo_next;
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            shade_q     <= SHADE_W'(quo_next[SHADE_FRAC-1:0]);
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_DIV_ROW: begin
          rem_q <= rem_next;
          quo_q <= quo_next;
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_SHADE;
        end
        S_SHADE: begin
          out_color_q <= pix_color;
          out_we_q    <= (pix_color != KEY_COLOR) && ({1'b0, row_q} < end_q);
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_we_q, out_color_q, out_y_q, out_x_q};

endmodule

// ===== rtl/textured_column_shader.sv =====
// textured wall column shader with distance shading
// input stream: one transaction per item; tuser carries the kind (texel load,
// column setup, pixel row, unused), tdata carries all other fields
// output stream: exactly one transaction per input item; texel loads, setups
// and the unused kind give an all-zero result, pixel rows give the column,
// the row, the shaded texel and the write enable
// config port: cfg_we_i writes light_gain (index 0) or vertical_shift
// (index 1) at the clock edge; the user must write only while the block
// is idle, which the block itself does not enforce
// the front is a two-entry queue that accepts items while the back works
// the back handles one item at a time with a shared restoring divider;
// texel loads, the unused kind, bright setups and rows outside the texture
// go straight to the output register; a setup with distance division first
// computes 8 quotient bits; a pixel row runs 6 divider steps, then the
// texture read and shade; a row just above the wall that maps to texture
// row zero skips the division; the next item starts only after the result
// has left; a stalled receiver holds the output register, the back stops
// and the queue fills, after which s_axis_tready_o drops
// reset clears the queue, the column state and the registers; the texture
// store holds no reset value and must be loaded before use
module textured_column_shader import tcs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // texel_index, texel_color, column, wall_frac, hit_side, step_x_negative,
  // step_y_positive, wall height, row_end, distance, row
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // kind
  input  logic [KIND_W-1:0]     s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // pixel_x, pixel_y, pixel_color, write_enable, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  front_t front;
  logic   pop;

  // accept and classify, buffer up to two transactions
  tcs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .front_o         (front),
    .pop_i           (pop)
  );

  // sequencer, divider, texture store and output register
  tcs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .front_i         (front),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

`ifndef ASSERT_OFF
  // an accepted transaction is visible to the back on the next cycle
  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> front.valid)
    else $error("accepted transaction not queued");

  // the back only takes items that exist
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> front.valid)
    else $error("pop from empty queue");

  // a key texel is never written
  a_no_key_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[53] |-> m_axis_tdata_o[52:21] != KEY_COLOR)
    else $error("key color written");
`endif

endmodule

// ===== tb/sv/tcs_checker.sv =====
module tcs_checker import tcs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [KIND_W-1:0]     s_axis_tuser_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  output int                    pending_o,
  output int                    fail_count_o
);

  typedef struct packed {
    logic [COL_W-1:0]   px;
    logic [ROW_W-1:0]   py;
    logic [COLOR_W-1:0] color;
    logic               we;
  } pixel_t;

  logic [COLOR_W-1:0]  texels [STORE_DEPTH];
  logic [GAIN_W-1:0]   gain = GAIN_RESET;
  logic [VSHIFT_W-1:0] vshift = '0;
  logic [COL_W-1:0]    col_x = '0;
  logic [TEX_W_LG-1:0] tex_col = '0;
  logic [HEIGHT_W-1:0] col_h = 16'd1;
  logic [END_W-1:0]    col_end = '0;
  logic [SHADE_W-1:0]  factor = '0;
  pixel_t              pixel_queue [$];
  int                  fails = 0;

  assign pending_o    = pixel_queue.size();
  assign fail_count_o = fails;

  function automatic logic [COLOR_W-1:0] shade_texel(logic [COLOR_W-1:0] c);
    logic [16:0] r, g, b;
    r = c[23:16] * factor;
    g = c[15:8] * factor;
    b = c[7:0] * factor;
    return {8'h00, r[15:8], g[15:8], b[15:8]};
  endfunction

  // update column state and return the expected transaction for one item
  function automatic pixel_t predict_pixel(kind_e k, logic [IN_DATA_W-1:0] d);
    pixel_t              p;
    logic [STORE_AW-1:0] idx;
    logic [FRAC_W-1:0]   frac;
    logic [ROW_W-1:0]    row;
    logic [HEIGHT_W-1:0] h;
    logic [DIST_W-1:0]   wall_dist;
    logic [31:0]         tc, f;
    longint              offset, ty;
    logic [COLOR_W-1:0]  color;
    p = '0;
    case (k)
      KIND_TEXEL: begin
        idx = d[11:0];
        texels[idx] = d[43:12];
      end
      KIND_SETUP: begin
        frac = d[69:54];
        tc = (32'(frac) * TEX_W) >> 16;
        if ((!d[70] && d[71]) || (d[70] && d[72])) tc = TEX_W - 1 - tc;
        wall_dist = d[116:101];
        if (wall_dist == 0) wall_dist = DIST_W'(1);
        f = (32'(gain) * 256) / wall_dist;
        if (f > 256) f = 256;
        h = d[88:73];
        col_x   = d[53:44];
        tex_col = tc[TEX_W_LG-1:0];
        col_h   = (h == 0) ? 16'd1 : h;
        col_end = d[100:89];
        factor  = f[SHADE_W-1:0];
      end
      KIND_PIXEL: begin
        row = d[127:117];
        offset = longint'(row) + longint'(col_h / 2) - SCREEN_H / 2
                 - longint'($signed(vshift));
        ty = (offset * TEX_H) / longint'(col_h);
        if (ty < 0 || ty >= TEX_H) color = '0;
        else color = texels[STORE_AW'(ty * TEX_W + tex_col)];
        if (color != KEY_COLOR) color = shade_texel(color);
        p.px    = col_x;
        p.py    = row;
        p.color = color;
        p.we    = (row < col_end) && (color != KEY_COLOR);
      end
      default: ;
    endcase
    return p;
  endfunction

  always @(posedge clk_i) begin
    pixel_t got, want;
    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_LIGHT_GAIN) gain = cfg_data_i;
      else if (cfg_idx_i == CFG_VSHIFT) vshift = cfg_data_i[VSHIFT_W-1:0];
    end
    if (s_axis_tvalid_i && s_axis_tready_i)
      pixel_queue.push_back(predict_pixel(kind_e'(s_axis_tuser_i), s_axis_tdata_i));
    if (m_axis_tvalid_i && m_axis_tready_i) begin
      got = {m_axis_tdata_i[9:0], m_axis_tdata_i[20:10], m_axis_tdata_i[52:21],
             m_axis_tdata_i[53]};
      if (pixel_queue.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected output transaction %h", m_axis_tdata_i);
      end else begin
        want = pixel_queue.pop_front();
        if (got != want || m_axis_tdata_i[55:54] != 2'b00) begin
          fails++;
          if (fails <= 10)
            $display("bad pixel: exp x=%0d y=%0d c=%h we=%b got x=%0d y=%0d c=%h we=%b",
                     want.px, want.py, want.color, want.we,
                     got.px, got.py, got.color, got.we);
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_textured_column_shader.sv =====
module tb_textured_column_shader;
  import tcs_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [KIND_W-1:0]     s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  int pending, fail_count;
  int sent = 0;
  int cycles = 0;
  bit hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  textured_column_shader uut (.*);

  tcs_checker chk (
    .clk_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .s_axis_tuser_i, .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o), .pending_o(pending), .fail_count_o(fail_count)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // receiver: random back-pressure plus one long hold-off when asked
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready_i = 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready_i = 1'b1;
      g = gap_len();
      if (g > 0) begin
        @(negedge clk_i);
        m_axis_tready_i = 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 1_500_000) begin
      $display("textured_column_shader: mismatch");
      $finish;
    end
  end

  function automatic logic [IN_DATA_W-1:0] noise();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // one input transaction, then a random gap
  task automatic send(kind_e k, logic [IN_DATA_W-1:0] d);
    int g;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = d;
    s_axis_tuser_i  = k;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent++;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  task automatic texel(int idx, logic [31:0] c);
    logic [IN_DATA_W-1:0] d;
    d = noise();
    d[11:0]  = 12'(idx);
    d[43:12] = c;
    send(KIND_TEXEL, d);
  endtask

  // the top three bits of the hit position are forced all equal, so that
  // setups only pick texture columns 0..7 and 56..63, even when mirrored
  task automatic setup(logic [15:0] frac, logic [2:0] sides, logic [15:0] h,
                       logic [11:0] rend, logic [15:0] wall_dist);
    logic [IN_DATA_W-1:0] d;
    d = noise();
    d[53:44]   = 10'($urandom);
    d[69:54]   = {{3{frac[15]}}, frac[12:0]};
    d[72:70]   = sides;
    d[88:73]   = h;
    d[100:89]  = rend;
    d[116:101] = wall_dist;
    send(KIND_SETUP, d);
  endtask

  task automatic pixel(logic [10:0] row);
    logic [IN_DATA_W-1:0] d;
    d = noise();
    d[127:117] = row;
    send(KIND_PIXEL, d);
  endtask

  // drain the block before touching the registers
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // a column setup followed by a run of pixel rows around the wall
  task automatic random_column();
    logic [15:0] h, wall_dist;
    int n, base;
    case ($urandom_range(0, 3))
      0: h = 16'($urandom_range(1, 64));
      1: h = 16'($urandom_range(64, 1100));
      2: h = 16'($urandom);
      default: h = 16'($urandom_range(0, 4));
    endcase
    case ($urandom_range(0, 3))
      0: wall_dist = 16'($urandom_range(0, 3));
      1: wall_dist = 16'($urandom_range(200, 2000));
      default: wall_dist = 16'($urandom);
    endcase
    setup(16'($urandom), 3'($urandom), h, 12'($urandom_range(0, 2048)), wall_dist);
    n = $urandom_range(5, 30);
    base = 512 - (h > 2000 ? 1000 : h / 2) - 4;
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) pixel(11'($urandom));
      else pixel(11'(base + $urandom_range(0, (h > 2000 ? 2000 : h) + 8)));
    end
  endtask

  initial begin
    int sets;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // load every texture column a setup can pick; the green key sits at
    // address 0 and elsewhere
    texel(0, KEY_COLOR);
    for (int i = 1; i < STORE_DEPTH; i++)
      if ((i % TEX_W) < 8 || (i % TEX_W) >= TEX_W - 8)
        texel(i, ($urandom_range(0, 15) == 0) ? KEY_COLOR : $urandom);
    texel(1, 32'hFFFF_FFFF);

    // directed corners
    setup(16'h0000, 3'b000, 16'd64, 12'd2048, 16'd0);
    pixel(11'd480);                     // key texel, not written
    pixel(11'd481);                     // random texel at full light
    pixel(11'd0);                       // above the texture
    pixel(11'd2047);                    // below the texture
    setup(16'hFFFF, 3'b010, 16'd0, 12'd0, 16'hFFFF);
    pixel(11'd512);                     // zero height latched as one, row past end
    setup(16'hE000, 3'b101, 16'hFFFF, 12'd600, 16'd1);
    pixel(11'd100);
    pixel(11'd599);
    pixel(11'd600);
    setup(16'h1C00, 3'b100, 16'd128, 12'd2047, 16'h0200);
    pixel(11'd500);
    setup(16'h1234, 3'b001, 16'd64, 12'd1024, 16'h0180);
    pixel(11'd481);
    send(KIND_NONE, noise());
    pixel(11'd482);

    // register settings, extremes first
    for (sets = 0; sets < 6; sets++) begin
      wait_idle();
      case (sets)
        0: begin write_reg(CFG_LIGHT_GAIN, 16'd0);     write_reg(CFG_VSHIFT, 16'h0400); end
        1: begin write_reg(CFG_LIGHT_GAIN, 16'hFFFF);  write_reg(CFG_VSHIFT, 16'h03FF); end
        2: begin write_reg(CFG_LIGHT_GAIN, GAIN_RESET); write_reg(CFG_VSHIFT, 16'h0000); end
        default: begin
          write_reg(CFG_LIGHT_GAIN, 16'($urandom));
          write_reg(CFG_VSHIFT, 16'($urandom_range(0, 2047)));
        end
      endcase
      // long receiver hold-off while the sender keeps going
      if (sets == 1) hold_req = 1'b1;
      // random items, about 1900 items in all
      while (sent < 1044 + (sets + 1) * 140) begin
        case ($urandom_range(0, 19))
          0: texel($urandom, ($urandom_range(0, 7) == 0) ? KEY_COLOR : $urandom);
          1: send(KIND_NONE, noise());
          2: setup(16'($urandom), 3'($urandom), 16'($urandom), 12'($urandom),
                   16'($urandom));
          default: random_column();
        endcase
        if (sets == 1 && !hold_req && $urandom_range(0, 40) == 0) hold_req = 1'b1;
        if (sets == 3 && $urandom_range(0, 3) == 0) wait_idle();
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("textured_column_shader: match");
    end else begin
      $display("textured_column_shader: mismatch");
    end
    $finish;
  end

endmodule
